[rtl/cvs_pkg.sv]
// ----------------------------------------------------------------------------
// Cell voltage statistics package
// Widths, limits and codes shared by the statistics block.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // Number of cells one pack may hold, and the widths that follow from it.
  localparam int MAX_CELLS = 32;
  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int COUNT_W   = 6;
  localparam int CELL_W    = 16;
  localparam int SUM_W     = 21;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Configuration register space.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CELL_W-1:0] MIN_START_RESET = 16'd5000;
  localparam logic REG_MIN_START = 1'b0;  // word index of the min_start register

  // Output word layout, highest field first.
  localparam int OUT_W = 88;

  typedef struct packed {
    logic [CELL_W-1:0]  median_mv;
    logic [CELL_W-1:0]  mean_mv;
    logic [CELL_W-1:0]  spread_mv;
    logic [CELL_W-1:0]  max_mv;
    logic [CELL_W-1:0]  min_mv;
    logic [COUNT_W-1:0] cell_count;
  } stats_t;

endpackage

[rtl/cell_voltage_statistics_core.sv]
// ----------------------------------------------------------------------------
// Cell voltage statistics core
// Collects one pack of cell voltages and reports count, minimum, maximum,
// spread, mean and median of the pack.
// ----------------------------------------------------------------------------
// Usage: cell voltages arrive on the s_axis group, one 16-bit millivolt word
// per cell, with s_tlast high on the final cell of the pack. Each ordinary
// cell is taken in a single cycle. The final cell starts the statistics
// pass, and s_tready stays low until the result has been placed in the
// output register. The result leaves on the m_axis group as one word.
// The mean comes from a restoring divider; the median search then takes each
// held cell in turn as candidate and compares every stored cell against it
// through the one shared subtractor and single read port of the cell memory.
// Reset clears the pack state and the output valid flag, and loads min_start
// with 5000. The output register parts the two sides: a new pack may be
// collected while a result waits, but the next result is held back until the
// receiver has taken the previous one. Cells beyond 32 are ignored, though a
// final marker on such a cell still closes the pack.
// ----------------------------------------------------------------------------
module cell_voltage_statistics_core (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] cell_voltage
  input  logic                          s_tlast,   // is_last
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cvs_pkg::OUT_W-1:0]     m_tdata,   // [5:0] cell_count, [21:6] min_mv,
                                                   // [37:22] max_mv, [53:38] spread_mv,
                                                   // [69:54] mean_mv, [85:70] median_mv,
                                                   // [87:86] zero
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvs_pkg::APB_AW-1:0]    paddr,
  input  logic [cvs_pkg::APB_DW-1:0]    pwdata,
  output logic [cvs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PREP,
    ST_DIV,
    ST_CAND,
    ST_CWAIT,
    ST_SCAN,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic [cvs_pkg::CELL_W-1:0] min_start;

  // Pack state
  logic [cvs_pkg::COUNT_W-1:0] cell_total;
  logic [cvs_pkg::SUM_W-1:0]   running_sum;
  logic [cvs_pkg::CELL_W-1:0]  running_min;
  logic [cvs_pkg::CELL_W-1:0]  running_max;

  // Cell memory, one write and one registered read port.
  logic [cvs_pkg::CELL_W-1:0] cell_store [cvs_pkg::MAX_CELLS];
  logic [cvs_pkg::IDX_W-1:0]  rd_addr;
  logic [cvs_pkg::CELL_W-1:0] rd_data;
  logic                       mem_we;

  // Divider state: the quotient shifts in where the dividend shifts out.
  logic [cvs_pkg::SUM_W-1:0]     quo;
  logic [cvs_pkg::COUNT_W-1:0]   rem;
  logic [cvs_pkg::DIV_CNT_W-1:0] div_cnt;

  // Median search state.
  logic [cvs_pkg::IDX_W-1:0]   cand_idx;
  logic [cvs_pkg::IDX_W-1:0]   scan_idx;
  logic [cvs_pkg::CELL_W-1:0]  cand;
  logic [cvs_pkg::COUNT_W-1:0] lt_cnt;
  logic [cvs_pkg::COUNT_W-1:0] le_cnt;
  logic [cvs_pkg::CELL_W-1:0]  med_lo;
  logic [cvs_pkg::CELL_W-1:0]  med_hi;

  // Output register.
  cvs_pkg::stats_t result;

  // Handshake and configuration decode.
  logic in_acc;
  logic has_room;
  logic cfg_wr;
  logic out_free;

  assign s_tready = (state == ST_COLLECT);
  assign in_acc   = s_tvalid && s_tready;
  assign has_room = (cell_total < cvs_pkg::COUNT_W'(cvs_pkg::MAX_CELLS));
  assign mem_we   = in_acc && has_room;
  assign out_free = !m_tvalid || m_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == cvs_pkg::REG_MIN_START);
  assign prdata = (paddr[2] == cvs_pkg::REG_MIN_START) ?
                  {{(cvs_pkg::APB_DW-cvs_pkg::CELL_W){1'b0}}, min_start} : '0;

  assign m_tdata = {2'b00, result};

  // The one shared subtractor. During the median scan it compares a stored
  // cell against the candidate; during division it is the trial subtraction.
  logic [cvs_pkg::CELL_W-1:0] alu_a;
  logic [cvs_pkg::CELL_W-1:0] alu_b;
  logic [cvs_pkg::CELL_W:0]   alu_diff;
  logic                       alu_borrow;
  logic                       alu_zero;

  always_comb begin
    if (state == ST_DIV) begin
      alu_a = {{(cvs_pkg::CELL_W-cvs_pkg::COUNT_W-1){1'b0}}, rem,
               quo[cvs_pkg::SUM_W-1]};
      alu_b = {{(cvs_pkg::CELL_W-cvs_pkg::COUNT_W){1'b0}}, cell_total};
    end else begin
      alu_a = rd_data;
      alu_b = cand;
    end
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[cvs_pkg::CELL_W];
  assign alu_zero   = (alu_diff[cvs_pkg::CELL_W-1:0] == '0);

  // Ranks of the two middle cells (the same for an odd count).
  logic [cvs_pkg::COUNT_W-1:0] last_pos;
  logic [cvs_pkg::COUNT_W-1:0] rank_lo;
  logic [cvs_pkg::COUNT_W-1:0] rank_hi;

  assign last_pos = cell_total - cvs_pkg::COUNT_W'(1);
  assign rank_lo  = last_pos >> 1;
  assign rank_hi  = cell_total >> 1;

  // Read address: candidate first, then a sweep over the held cells with the
  // next address issued while the current cell is compared.
  always_comb begin
    case (state)
      ST_CAND:  rd_addr = cand_idx;
      ST_CWAIT: rd_addr = '0;
      ST_SCAN:  rd_addr = scan_idx + cvs_pkg::IDX_W'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_store[cell_total[cvs_pkg::IDX_W-1:0]] <= s_tdata;
    end
    rd_data <= cell_store[rd_addr];
  end

  logic [cvs_pkg::CELL_W:0] mid_sum;
  assign mid_sum = {1'b0, med_lo} + {1'b0, med_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_COLLECT;
      min_start   <= cvs_pkg::MIN_START_RESET;
      cell_total  <= '0;
      running_sum <= '0;
      running_min <= cvs_pkg::MIN_START_RESET;
      running_max <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        min_start <= pwdata[cvs_pkg::CELL_W-1:0];
      end
      // A word taken while the next one is finishing is replaced below.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_COLLECT: begin
          if (mem_we) begin
            cell_total  <= cell_total + cvs_pkg::COUNT_W'(1);
            running_sum <= running_sum + cvs_pkg::SUM_W'(s_tdata);
            if (s_tdata > running_max) begin
              running_max <= s_tdata;
            end
            // The first cell of a pack starts from the current ceiling.
            if (cell_total == '0) begin
              running_min <= (s_tdata < min_start) ? s_tdata : min_start;
            end else if (s_tdata < running_min) begin
              running_min <= s_tdata;
            end
          end
          if (in_acc && s_tlast) begin
            state <= ST_PREP;
          end
        end

        ST_PREP: begin
          quo      <= running_sum;
          rem      <= '0;
          div_cnt  <= '0;
          cand_idx <= '0;
          state    <= ST_DIV;
        end

        ST_DIV: begin
          if (!alu_borrow) begin
            rem <= alu_diff[cvs_pkg::COUNT_W-1:0];
          end else begin
            rem <= alu_a[cvs_pkg::COUNT_W-1:0];
          end
          quo <= {quo[cvs_pkg::SUM_W-2:0], !alu_borrow};
          if (div_cnt == cvs_pkg::DIV_CNT_W'(cvs_pkg::SUM_W - 1)) begin
            state <= ST_CAND;
          end else begin
            div_cnt <= div_cnt + cvs_pkg::DIV_CNT_W'(1);
          end
        end

        ST_CAND: begin
          state <= ST_CWAIT;
        end

        ST_CWAIT: begin
          cand     <= rd_data;
          lt_cnt   <= '0;
          le_cnt   <= '0;
          scan_idx <= '0;
          state    <= ST_SCAN;
        end

        ST_SCAN: begin
          lt_cnt <= lt_cnt + cvs_pkg::COUNT_W'(alu_borrow);
          le_cnt <= le_cnt + cvs_pkg::COUNT_W'(alu_borrow | alu_zero);
          if ({1'b0, scan_idx} == last_pos) begin
            state <= ST_CHECK;
          end else begin
            scan_idx <= scan_idx + cvs_pkg::IDX_W'(1);
          end
        end

        ST_CHECK: begin
          // The candidate occupies sorted ranks lt_cnt up to le_cnt - 1.
          if (lt_cnt <= rank_lo && rank_lo < le_cnt) begin
            med_lo <= cand;
          end
          if (lt_cnt <= rank_hi && rank_hi < le_cnt) begin
            med_hi <= cand;
          end
          if ({1'b0, cand_idx} == last_pos) begin
            state <= ST_FINISH;
          end else begin
            cand_idx <= cand_idx + cvs_pkg::IDX_W'(1);
            state    <= ST_CAND;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            result.cell_count <= cell_total;
            result.min_mv     <= running_min;
            result.max_mv     <= running_max;
            result.spread_mv  <= running_max - running_min;
            result.mean_mv    <= quo[cvs_pkg::CELL_W-1:0];
            result.median_mv  <= mid_sum[cvs_pkg::CELL_W:1];
            m_tvalid          <= 1'b1;
            cell_total        <= '0;
            running_sum       <= '0;
            running_min       <= min_start;
            running_max       <= '0;
            state             <= ST_COLLECT;
          end
        end

        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell voltage statistics core testbench
// Streams packs of cell voltages into the core and checks every statistics
// word it returns against a cycle-free bench predictor, or a typed word from
// its table row. A short table of hand-picked cells comes first, then random
// packs of random length under changing min_start settings, random idling on
// both streams, one long receiver stall and drained pauses for register writes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 900000;
  localparam int TARGET_CELLS    = 1850;
  localparam int MAX_IDLE        = 13;
  localparam int LONG_HOLD       = 3000;
  localparam int PACKS_PER_PHASE = 8;
  localparam int QUIET_CYCLES    = 16;    // an ordinary cell is taken in one cycle
  localparam int SETTLE_CYCLES   = 1200;  // longer than the statistics pass of a full pack
  localparam int NUM_DIRECTED    = 18;

  // Byte address of min_start, and the next word, which holds no register.
  localparam logic [cvs_pkg::APB_AW-1:0] MIN_START_ADDR =
    cvs_pkg::APB_AW'(cvs_pkg::REG_MIN_START) << 2;
  localparam logic [cvs_pkg::APB_AW-1:0] SPARE_ADDR =
    MIN_START_ADDR + cvs_pkg::APB_AW'(4);

  // How the voltages of one random pack are spread.
  typedef enum int {
    SPREAD_WIDE,   // anywhere in the 16-bit range
    SPREAD_CELLS,  // the range of real lithium cells
    SPREAD_RAILS,  // mostly the two ends of the range
    SPREAD_TIGHT   // a narrow cluster, often with repeats
  } value_style_t;

  // One row of the directed table. Where typed is set, want holds the word
  // that the final cell of the pack must produce; otherwise the predictor
  // supplies it.
  typedef struct {
    logic [cvs_pkg::CELL_W-1:0] mv;
    bit                         last;
    bit                         typed;
    cvs_pkg::stats_t            want;
  } cell_row_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [15:0]                s_tdata;   // [15:0] cell_voltage
  logic                       s_tlast;   // is_last
  logic                       m_tvalid;
  logic                       m_tready;
  logic [cvs_pkg::OUT_W-1:0]  m_tdata;   // [5:0] cell_count, [21:6] min_mv,
                                         // [37:22] max_mv, [53:38] spread_mv,
                                         // [69:54] mean_mv, [85:70] median_mv
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [cvs_pkg::APB_AW-1:0] paddr;
  logic [cvs_pkg::APB_DW-1:0] pwdata;
  logic [cvs_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  // Predictor copy of the pack state and of the min_start register.
  logic [cvs_pkg::CELL_W-1:0] held_cells [cvs_pkg::MAX_CELLS];
  int                         held_count;
  logic [cvs_pkg::SUM_W-1:0]  held_sum;
  logic [cvs_pkg::CELL_W-1:0] held_min;
  logic [cvs_pkg::CELL_W-1:0] held_max;
  logic [cvs_pkg::CELL_W-1:0] min_start_shadow;

  // Statistics words still owed by the core, oldest first.
  cvs_pkg::stats_t pending_stats [$];

  int cells_sent  = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  int rx_hold_req = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;

  cell_voltage_statistics_core i_dut (.*);

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cvs_pkg::stats_t mk_stats(input int unsigned count,
                                               input int unsigned lo,
                                               input int unsigned hi,
                                               input int unsigned spread,
                                               input int unsigned mean,
                                               input int unsigned median);
    cvs_pkg::stats_t s;
    s.cell_count = cvs_pkg::COUNT_W'(count);
    s.min_mv     = cvs_pkg::CELL_W'(lo);
    s.max_mv     = cvs_pkg::CELL_W'(hi);
    s.spread_mv  = cvs_pkg::CELL_W'(spread);
    s.mean_mv    = cvs_pkg::CELL_W'(mean);
    s.median_mv  = cvs_pkg::CELL_W'(median);
    return s;
  endfunction

  // Folds one accepted cell into the predicted pack. On the final cell it
  // returns 1 with the statistics word in res and starts a fresh pack.
  function automatic bit fold_cell(input logic [cvs_pkg::CELL_W-1:0] mv, input bit last,
                                   output cvs_pkg::stats_t res);
    logic [cvs_pkg::CELL_W-1:0] sorted [cvs_pkg::MAX_CELLS];
    logic [cvs_pkg::CELL_W-1:0] key;
    int a;
    int b;
    int n;
    res = '0;
    // Cells beyond a full store are dropped, though their final marker counts.
    if (held_count < cvs_pkg::MAX_CELLS) begin
      if (held_count == 0) held_min = min_start_shadow;
      held_cells[held_count] = mv;
      held_count++;
      held_sum += mv;
      if (mv > held_max) held_max = mv;
      if (mv < held_min) held_min = mv;
    end
    if (!last) return 1'b0;
    n = held_count;
    for (a = 0; a < n; a++) sorted[a] = held_cells[a];
    for (a = 1; a < n; a++) begin
      key = sorted[a];
      b = a;
      while (b > 0 && sorted[b-1] > key) begin
        sorted[b] = sorted[b-1];
        b--;
      end
      sorted[b] = key;
    end
    res.cell_count = cvs_pkg::COUNT_W'(n);
    res.min_mv     = held_min;
    res.max_mv     = held_max;
    res.spread_mv  = held_max - held_min;
    res.mean_mv    = cvs_pkg::CELL_W'(held_sum / n);
    if (n % 2 != 0) begin
      res.median_mv = sorted[n/2];
    end else begin
      res.median_mv = cvs_pkg::CELL_W'(({1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]}) >> 1);
    end
    held_count = 0;
    held_sum   = '0;
    held_min   = min_start_shadow;
    held_max   = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Offers one cell word after a random gap, if idling is enabled, and waits
  // for it to be taken. The valid line is left high on return, so the next call
  // either replaces the word in the same step or lowers valid for its own gap.
  task automatic send_cell(input logic [cvs_pkg::CELL_W-1:0] mv, input bit last,
                           input bit typed, input cvs_pkg::stats_t want);
    int              gap;
    cvs_pkg::stats_t predicted;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mv;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (held_count < cvs_pkg::MAX_CELLS || last) cells_sent++;
    if (fold_cell(mv, last, predicted)) pending_stats.push_back(typed ? want : predicted);
  endtask

  task automatic send_pack(input int n);
    value_style_t               style;
    logic [cvs_pkg::CELL_W-1:0] base;
    logic [cvs_pkg::CELL_W-1:0] mv;
    int k;
    style = value_style_t'($urandom_range(0, 3));
    base  = cvs_pkg::CELL_W'($urandom_range(0, 16'hFFF8));
    for (k = 0; k < n; k++) begin
      case (style)
        SPREAD_WIDE:  mv = cvs_pkg::CELL_W'($urandom_range(0, 16'hFFFF));
        SPREAD_CELLS: mv = cvs_pkg::CELL_W'($urandom_range(2500, 4300));
        SPREAD_RAILS: begin
          case ($urandom_range(0, 2))
            0:       mv = '0;
            1:       mv = '1;
            default: mv = cvs_pkg::CELL_W'($urandom);
          endcase
        end
        default:      mv = base + cvs_pkg::CELL_W'($urandom_range(0, 7));
      endcase
      send_cell(mv, k == n - 1, 1'b0, '0);
    end
  endtask

  // Stops offering cells and waits until every owed word has been taken,
  // then QUIET_CYCLES more, so that the core is idle afterwards.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes one register word, then reads min_start back through the same
  // selection. The upper data bits carry noise that the register must drop.
  task automatic write_register(input logic [cvs_pkg::APB_AW-1:0] addr,
                                input logic [cvs_pkg::CELL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= (cvs_pkg::APB_DW'($urandom) << cvs_pkg::CELL_W) | cvs_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == MIN_START_ADDR) min_start_shadow = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MIN_START_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", cvs_pkg::APB_DW'(min_start_shadow), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: takes each statistics word after its own random stall when
  // idling is enabled, or after the long hold when the stimulus asks for one,
  // and compares it with the oldest owed word.
  initial begin : result_sink
    int              gap;
    cvs_pkg::stats_t got;
    cvs_pkg::stats_t want;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        gap = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = cvs_pkg::stats_t'(m_tdata[$bits(cvs_pkg::stats_t)-1:0]);
      if (pending_stats.size() == 0) begin
        $error("statistics word with no pack outstanding: %h", got);
        fail_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("cell_count", want.cell_count, got.cell_count);
        check_field("min_mv",     want.min_mv,     got.min_mv);
        check_field("max_mv",     want.max_mv,     got.max_mv);
        check_field("spread_mv",  want.spread_mv,  got.spread_mv);
        check_field("mean_mv",    want.mean_mv,    got.mean_mv);
        check_field("median_mv",  want.median_mv,  got.median_mv);
      end
    end
  end

  initial begin : stimulus
    cell_row_t directed_rows [NUM_DIRECTED];
    int phase;
    int k;
    int r;
    int n;

    // Predictor state after reset.
    min_start_shadow = cvs_pkg::MIN_START_RESET;
    held_count       = 0;
    held_sum         = '0;
    held_min         = cvs_pkg::MIN_START_RESET;
    held_max         = '0;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    // Directed packs, all under the reset value of min_start (5000). A single
    // cell of zero, a single cell and a pair at full scale (the minimum stays
    // at min_start and the sum needs more than 16 bits), an even pair whose
    // median rounds down, an unsorted odd and even pack, alternating bit
    // patterns, and single cells just below, at and above min_start.
    directed_rows[0]  = '{16'd0,     1'b1, 1'b1, mk_stats(1, 0, 0, 0, 0, 0)};
    directed_rows[1]  = '{16'd65535, 1'b1, 1'b1, mk_stats(1, 5000, 65535, 60535, 65535, 65535)};
    directed_rows[2]  = '{16'd65535, 1'b0, 1'b0, '0};
    directed_rows[3]  = '{16'd65535, 1'b1, 1'b1, mk_stats(2, 5000, 65535, 60535, 65535, 65535)};
    directed_rows[4]  = '{16'd1,     1'b0, 1'b0, '0};
    directed_rows[5]  = '{16'd2,     1'b1, 1'b1, mk_stats(2, 1, 2, 1, 1, 1)};
    directed_rows[6]  = '{16'd300,   1'b0, 1'b0, '0};
    directed_rows[7]  = '{16'd100,   1'b0, 1'b0, '0};
    directed_rows[8]  = '{16'd200,   1'b1, 1'b1, mk_stats(3, 100, 300, 200, 200, 200)};
    directed_rows[9]  = '{16'd4000,  1'b0, 1'b0, '0};
    directed_rows[10] = '{16'd1000,  1'b0, 1'b0, '0};
    directed_rows[11] = '{16'd3000,  1'b0, 1'b0, '0};
    directed_rows[12] = '{16'd2000,  1'b1, 1'b0, '0};
    directed_rows[13] = '{16'hAAAA,  1'b0, 1'b0, '0};
    directed_rows[14] = '{16'h5555,  1'b1, 1'b0, '0};
    directed_rows[15] = '{16'd4999,  1'b1, 1'b1, mk_stats(1, 4999, 4999, 0, 4999, 4999)};
    directed_rows[16] = '{16'd5000,  1'b1, 1'b1, mk_stats(1, 5000, 5000, 0, 5000, 5000)};
    directed_rows[17] = '{16'd5001,  1'b1, 1'b1, mk_stats(1, 5000, 5001, 1, 5001, 5001)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_cell(directed_rows[k].mv, directed_rows[k].last, directed_rows[k].typed,
                directed_rows[k].want);
    end

    // A pack that fills the store exactly, then one that runs past it, so
    // that the extra cells are dropped and the final marker on a dropped
    // cell still closes the pack.
    send_pack(cvs_pkg::MAX_CELLS);
    send_pack(cvs_pkg::MAX_CELLS + 4);

    // Random phases. Each starts from an idle core with a new register
    // setting: both ends of the range, a value among real cell voltages, a
    // random value, a write to the empty word that must change nothing, and
    // the reset value again.
    phase = 0;
    while (cells_sent < TARGET_CELLS) begin
      drain_results();
      case (phase % 6)
        0:       write_register(MIN_START_ADDR, 16'hFFFF);
        1:       write_register(MIN_START_ADDR, 16'h0000);
        2:       write_register(MIN_START_ADDR, cvs_pkg::CELL_W'($urandom_range(2500, 4300)));
        3:       write_register(MIN_START_ADDR, cvs_pkg::CELL_W'($urandom));
        4:       write_register(SPARE_ADDR, cvs_pkg::CELL_W'($urandom));
        default: write_register(MIN_START_ADDR, cvs_pkg::MIN_START_RESET);
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // Once, the receiver stalls for a long stretch while cells keep
      // coming, so that the output register fills and the core holds off the
      // cells that follow the final cell of the next pack.
      if (phase == 2) begin
        rx_hold_req = LONG_HOLD;
        tx_idle     = 1'b0;
      end
      repeat (PACKS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 70)      n = $urandom_range(1, 8);
        else if (r < 90) n = $urandom_range(9, 20);
        else if (r < 95) n = $urandom_range(21, cvs_pkg::MAX_CELLS - 1);
        else if (r < 98) n = cvs_pkg::MAX_CELLS;
        else             n = $urandom_range(cvs_pkg::MAX_CELLS + 1, cvs_pkg::MAX_CELLS + 8);
        send_pack(n);
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cvs_pkg.sv
rtl/cell_voltage_statistics_core.sv
tb/sv/tb_top.sv
